@@ design/rsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants of the room seat allocator
// Holds the codes of modes, results, configuration registers and the
// sequencer, and the structs that travel between the allocator's modules.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int MAX_ROOMS_DEF = 16;
  localparam int TYPE_COUNT    = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEAT_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LIMIT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINGER_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_MASK    = 8'd3;

  localparam logic [7:0]  SEAT_CAPACITY_RST = 8'd8;
  localparam logic [4:0]  TYPE_LIMIT_RST    = 5'd0;
  localparam logic [15:0] LINGER_TICKS_RST  = 16'd1;
  localparam logic [15:0] KNOWN_MASK_RST    = 16'd0;

  typedef enum logic [1:0] {
    MODE_JOIN  = 2'd0,
    MODE_LEAVE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_REAP  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_JOINED     = 4'd0,
    ST_JOINED_PREF = 4'd1,
    ST_CREATED    = 4'd2,
    ST_UNKNOWN    = 4'd3,
    ST_TYPE_LIMIT = 4'd4,
    ST_TABLE_FULL = 4'd5,
    ST_LEFT       = 4'd6,
    ST_LEAVE_MISS = 4'd7,
    ST_TICKED     = 4'd8,
    ST_REAPED     = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    SQ_IDLE   = 2'd0,
    SQ_SCAN   = 2'd1,
    SQ_FINISH = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  kind;
    logic [7:0]  seats;
    logic [15:0] idle;
  } slot_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  room_type;
    logic [31:0] preferred_room;
    logic [31:0] leaving_room;
  } item_t;

  typedef struct packed {
    logic [7:0]  cap;
    logic [4:0]  limit;
    logic [15:0] linger;
    logic [15:0] mask;
  } cfg_t;

  typedef struct packed {
    logic hit;
    logic kind_hit;
    logic better;
    logic free;
    logic age;
    logic reap;
  } eval_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] granted_room;
    logic [7:0]  seats_taken;
    logic [4:0]  rooms_freed;
    logic [4:0]  open_rooms;
    logic [11:0] total_seats;
  } result_t;

endpackage

@@ design/rsa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_in_if: request channel of the room seat allocator
// Carries one request word with valid and ready.
// ----------------------------------------------------------------------------
interface rsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  room_type;
  logic [31:0] preferred_room;
  logic [31:0] leaving_room;

  modport source (output valid, mode, room_type, preferred_room, leaving_room,
                  input ready);
  modport sink   (input valid, mode, room_type, preferred_room, leaving_room,
                  output ready);
endinterface

@@ design/rsa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_out_if: result channel of the room seat allocator
// Carries one result word with valid and ready.
// ----------------------------------------------------------------------------
interface rsa_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] granted_room;
  logic [7:0]  seats_taken;
  logic [4:0]  rooms_freed;
  logic [4:0]  open_rooms;
  logic [11:0] total_seats;

  modport source (output valid, status, granted_room, seats_taken, rooms_freed,
                  open_rooms, total_seats, input ready);
  modport sink   (input valid, status, granted_room, seats_taken, rooms_freed,
                  open_rooms, total_seats, output ready);
endinterface

@@ design/rsa_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_cfg_if: configuration write channel of the room seat allocator
// Carries a register index and write data with valid and ready.
// ----------------------------------------------------------------------------
interface rsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rsa_pkg::CFG_IDX_W-1:0]  index;
  logic [rsa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/rsa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rsa_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_cfg_regs: configuration registers of the room seat allocator
// Decodes register writes and presents the effective settings, with a zero
// capacity or zero linger time read as one.
// ----------------------------------------------------------------------------
module rsa_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  rsa_cfg_if.sink        cfg_ch,
  output rsa_pkg::cfg_t  cfg
);

  logic [7:0]  cap_r;
  logic [4:0]  limit_r;
  logic [15:0] linger_r;
  logic [15:0] mask_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= rsa_pkg::SEAT_CAPACITY_RST;
      limit_r  <= rsa_pkg::TYPE_LIMIT_RST;
      linger_r <= rsa_pkg::LINGER_TICKS_RST;
      mask_r   <= rsa_pkg::KNOWN_MASK_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rsa_pkg::CFG_SEAT_CAPACITY: cap_r    <= cfg_ch.data[7:0];
        rsa_pkg::CFG_TYPE_LIMIT:    limit_r  <= cfg_ch.data[4:0];
        rsa_pkg::CFG_LINGER_TICKS:  linger_r <= cfg_ch.data[15:0];
        rsa_pkg::CFG_KNOWN_MASK:    mask_r   <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cap    = (cap_r == 8'd0) ? 8'd1 : cap_r;
    cfg.limit  = limit_r;
    cfg.linger = (linger_r == 16'd0) ? 16'd1 : linger_r;
    cfg.mask   = mask_r;
  end

endmodule

@@ design/rsa_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_scan: shared slot compare unit
// Judges one slot word against the current request: id match, type match,
// free seat, better candidate, free slot, aging and reaping.
// ----------------------------------------------------------------------------
module rsa_scan (
  input  rsa_pkg::slot_t  slot,
  input  logic            slot_valid,
  input  rsa_pkg::item_t  item,
  input  rsa_pkg::cfg_t   cfg,
  input  logic            best_vld,
  input  logic [31:0]     best_id,
  output rsa_pkg::eval_t  ev
);

  logic kind_hit;
  logic space;
  logic empty;

  always_comb begin
    kind_hit = slot_valid && (slot.kind == item.room_type);
    space    = slot.seats < cfg.cap;
    empty    = slot_valid && (slot.seats == 8'd0);

    ev.kind_hit = kind_hit;
    ev.better   = kind_hit && space && (!best_vld || (slot.id < best_id));
    ev.free     = !slot_valid;
    ev.age      = (item.mode == rsa_pkg::MODE_TICK) && empty && (slot.idle != 16'hFFFF);
    ev.reap     = (item.mode == rsa_pkg::MODE_REAP) && empty && (slot.idle >= cfg.linger);

    case (item.mode)
      rsa_pkg::MODE_JOIN:  ev.hit = (item.preferred_room != 32'd0) && kind_hit && space &&
                                    (slot.id == item.preferred_room);
      rsa_pkg::MODE_LEAVE: ev.hit = slot_valid && (item.leaving_room != 32'd0) &&
                                    (slot.id == item.leaving_room);
      default:             ev.hit = 1'b0;
    endcase
  end

endmodule

@@ design/room_seat_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_seat_allocator: room table with seat allocation, aging and reaping
// Sequencer that walks the room table through one compare unit per request.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as words on in_ch: join a room of a type, leave a
// room by id, age the empty rooms by one tick, or reap empty rooms that have
// lingered long enough. Every request gives exactly one result word on out_ch
// with a status, the room joined or left, its seat count, the number of rooms
// freed and the room and seat totals after the request.
// Settings are written on cfg_ch, which is always ready; write them only
// while the block is idle.
// Timing. A request walks all MAX_ROOMS slots of the table RAM, one slot a
// cycle through the shared compare unit, and is then decided in a finish
// step. The result word is registered and appears the cycle after the
// finish step. in_ch is ready only while the sequencer is idle.
// Stalls. A result waiting on out_ch does not keep the next request from
// being accepted and scanned; that request holds in its finish step until
// the result register is free.
// Reset. All rooms are invalid, the totals are zero, the next room id is one
// and the settings take their reset values. The slot RAM is not cleared: a
// slot's contents are read only after its valid bit has been set.
// ----------------------------------------------------------------------------
module room_seat_allocator #(
  parameter int MAX_ROOMS = rsa_pkg::MAX_ROOMS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rsa_in_if.sink   in_ch,
  rsa_out_if.source out_ch,
  rsa_cfg_if.sink  cfg_ch
);

  localparam int IDX_W = $clog2(MAX_ROOMS);
  localparam int CNT_W = $clog2(MAX_ROOMS + 1);

  // Sequencer state and the request being worked on.
  rsa_pkg::seq_state_t state_r, state_nxt;
  rsa_pkg::item_t      item_r;
  rsa_pkg::cfg_t       cfg;

  // Scan pointers: the address sent to the RAM and the slot whose data is back.
  logic [CNT_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0] ev_idx_r;
  logic             ev_vld_r;

  // Table state held in flip-flops.
  logic [MAX_ROOMS-1:0] valid_r;
  logic [31:0]          next_id_r;
  logic [CNT_W-1:0]     open_r;
  logic [11:0]          sum_r;

  // What the scan has found so far.
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  rsa_pkg::slot_t   hit_word_r;
  logic             best_vld_r;
  logic [IDX_W-1:0] best_idx_r;
  rsa_pkg::slot_t   best_word_r;
  logic             free_vld_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] freed_r;

  // Result register.
  logic              out_vld_r;
  rsa_pkg::result_t  res_r;

  logic           in_take;
  logic           issue;
  logic           ev_last;
  logic           out_free;
  logic           fin_go;
  rsa_pkg::slot_t rd_word;
  rsa_pkg::eval_t ev;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rsa_pkg::slot_t   ram_wdata;
  rsa_pkg::slot_t   age_word;

  // Finish step results.
  logic             type_known;
  logic             fin_we;
  logic [IDX_W-1:0] fin_idx;
  rsa_pkg::slot_t   fin_word;
  logic             fin_create;
  rsa_pkg::result_t fin_res;
  logic [CNT_W-1:0] open_nxt;
  logic [11:0]      sum_nxt;
  logic [31:0]      next_id_nxt;

  rsa_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rsa_ram #(
    .WIDTH ($bits(rsa_pkg::slot_t)),
    .DEPTH (MAX_ROOMS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (rd_word)
  );

  rsa_scan u_scan (
    .slot       (rd_word),
    .slot_valid (valid_r[ev_idx_r]),
    .item       (item_r),
    .cfg        (cfg),
    .best_vld   (best_vld_r),
    .best_id    (best_word_r.id),
    .ev         (ev)
  );

  assign out_free = !out_vld_r || out_ch.ready;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign ev_last  = ev_vld_r && (ev_idx_r == IDX_W'(MAX_ROOMS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsa_pkg::SQ_IDLE:   if (in_ch.valid) state_nxt = rsa_pkg::SQ_SCAN;
      rsa_pkg::SQ_SCAN:   if (ev_last) state_nxt = rsa_pkg::SQ_FINISH;
      rsa_pkg::SQ_FINISH: if (out_free) state_nxt = rsa_pkg::SQ_IDLE;
      default:            state_nxt = rsa_pkg::SQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    fin_go      = 1'b0;
    case (state_r)
      rsa_pkg::SQ_IDLE:   in_ch.ready = 1'b1;
      rsa_pkg::SQ_SCAN:   issue = scan_cnt_r < CNT_W'(MAX_ROOMS);
      rsa_pkg::SQ_FINISH: fin_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsa_pkg::SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A tick ages an empty slot in place while the scan moves on.
  always_comb begin
    age_word      = rd_word;
    age_word.idle = rd_word.idle + 16'd1;
  end

  // The finish step writes at most one slot; during a scan the tick writes back.
  always_comb begin
    if (fin_go) begin
      ram_we    = fin_we;
      ram_waddr = fin_idx;
      ram_wdata = fin_word;
    end else begin
      ram_we    = ev_vld_r && ev.age;
      ram_waddr = ev_idx_r;
      ram_wdata = age_word;
    end
  end

  // Finish step: decide the request from what the scan found.
  always_comb begin
    type_known  = (int'(item_r.room_type) < rsa_pkg::TYPE_COUNT) &&
                  cfg.mask[item_r.room_type];
    fin_we      = 1'b0;
    fin_idx     = hit_idx_r;
    fin_word    = hit_word_r;
    fin_create  = 1'b0;
    open_nxt    = open_r;
    sum_nxt     = sum_r;
    next_id_nxt = next_id_r;

    fin_res.status       = rsa_pkg::ST_TICKED;
    fin_res.granted_room = 32'd0;
    fin_res.seats_taken  = 8'd0;
    fin_res.rooms_freed  = 5'd0;

    case (item_r.mode)
      rsa_pkg::MODE_JOIN: begin
        if (!type_known) begin
          fin_res.status = rsa_pkg::ST_UNKNOWN;
        end else if (hit_r || best_vld_r) begin
          // The preferred room wins over the lowest-id room with space.
          if (!hit_r) begin
            fin_idx  = best_idx_r;
            fin_word = best_word_r;
          end
          fin_word.seats       = fin_word.seats + 8'd1;
          fin_we               = 1'b1;
          sum_nxt              = sum_r + 12'd1;
          fin_res.status       = hit_r ? rsa_pkg::ST_JOINED_PREF : rsa_pkg::ST_JOINED;
          fin_res.granted_room = fin_word.id;
          fin_res.seats_taken  = fin_word.seats;
        end else if ((cfg.limit != 5'd0) && (32'(count_r) >= 32'(cfg.limit))) begin
          fin_res.status = rsa_pkg::ST_TYPE_LIMIT;
        end else if (!free_vld_r) begin
          fin_res.status = rsa_pkg::ST_TABLE_FULL;
        end else begin
          fin_idx              = free_idx_r;
          fin_word.id          = next_id_r;
          fin_word.kind        = item_r.room_type;
          fin_word.seats       = 8'd1;
          fin_word.idle        = 16'd0;
          fin_we               = 1'b1;
          fin_create           = 1'b1;
          open_nxt             = open_r + CNT_W'(1);
          sum_nxt              = sum_r + 12'd1;
          // Room ids wrap around and never take the value zero.
          next_id_nxt          = (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
          fin_res.status       = rsa_pkg::ST_CREATED;
          fin_res.granted_room = next_id_r;
          fin_res.seats_taken  = 8'd1;
        end
      end
      rsa_pkg::MODE_LEAVE: begin
        if (hit_r) begin
          if (hit_word_r.seats != 8'd0) begin
            fin_word.seats = hit_word_r.seats - 8'd1;
            sum_nxt        = sum_r - 12'd1;
          end
          // A room that ends empty starts its idle time again.
          if (fin_word.seats == 8'd0) begin
            fin_word.idle = 16'd0;
          end
          fin_we               = 1'b1;
          fin_res.status       = rsa_pkg::ST_LEFT;
          fin_res.granted_room = item_r.leaving_room;
          fin_res.seats_taken  = fin_word.seats;
        end else begin
          fin_res.status = rsa_pkg::ST_LEAVE_MISS;
        end
      end
      rsa_pkg::MODE_TICK: begin
        fin_res.status = rsa_pkg::ST_TICKED;
      end
      default: begin
        fin_res.status      = rsa_pkg::ST_REAPED;
        fin_res.rooms_freed = 5'(freed_r);
        open_nxt            = open_r - freed_r;
      end
    endcase

    fin_res.open_rooms  = 5'(open_nxt);
    fin_res.total_seats = sum_nxt;
  end

  // Scan pointers and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      ev_vld_r   <= 1'b0;
      ev_idx_r   <= '0;
      hit_r      <= 1'b0;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
      count_r    <= '0;
      freed_r    <= '0;
    end else if (in_take) begin
      scan_cnt_r <= '0;
      ev_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
      count_r    <= '0;
      freed_r    <= '0;
    end else begin
      ev_vld_r <= issue;
      ev_idx_r <= scan_cnt_r[IDX_W-1:0];
      if (issue) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
      if (ev_vld_r) begin
        // Only the first matching slot counts for an id match.
        if (ev.hit && !hit_r) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= ev_idx_r;
          hit_word_r <= rd_word;
        end
        if (ev.better) begin
          best_vld_r  <= 1'b1;
          best_idx_r  <= ev_idx_r;
          best_word_r <= rd_word;
        end
        if (ev.free && !free_vld_r) begin
          free_vld_r <= 1'b1;
          free_idx_r <= ev_idx_r;
        end
        if (ev.kind_hit) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (ev.reap) begin
          freed_r <= freed_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode           <= rsa_pkg::mode_t'(in_ch.mode);
      item_r.room_type      <= in_ch.room_type;
      item_r.preferred_room <= in_ch.preferred_room;
      item_r.leaving_room   <= in_ch.leaving_room;
    end
  end

  // Table state kept in flip-flops: valid bits, totals and the next id.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      next_id_r <= 32'd1;
      open_r    <= '0;
      sum_r     <= '0;
    end else begin
      if (ev_vld_r && ev.reap && (state_r == rsa_pkg::SQ_SCAN)) begin
        valid_r[ev_idx_r] <= 1'b0;
      end
      if (fin_go) begin
        if (fin_create) begin
          valid_r[fin_idx] <= 1'b1;
        end
        next_id_r <= next_id_nxt;
        open_r    <= open_nxt;
        sum_r     <= sum_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res_r <= fin_res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.granted_room = res_r.granted_room;
  assign out_ch.seats_taken  = res_r.seats_taken;
  assign out_ch.rooms_freed  = res_r.rooms_freed;
  assign out_ch.open_rooms   = res_r.open_rooms;
  assign out_ch.total_seats  = res_r.total_seats;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the room seat allocator
// Sends join, leave, tick and reap request words with random gaps and checks
// every result word against a room table kept inside the bench. The settings
// are rewritten between phases, including their extreme values.
// ----------------------------------------------------------------------------
import rsa_pkg::*;

// Room ledger: the bench's own copy of the room table and the settings. It
// works out the result word of every accepted request and holds the results
// still owed by the block.
class seat_ledger;
  bit          room_valid[MAX_ROOMS_DEF];
  bit [31:0]   room_id[MAX_ROOMS_DEF];
  bit [3:0]    room_kind[MAX_ROOMS_DEF];
  bit [7:0]    room_seats[MAX_ROOMS_DEF];
  bit [15:0]   room_idle[MAX_ROOMS_DEF];
  bit [31:0]   next_room_id;
  bit [7:0]    cap;
  bit [4:0]    limit;
  bit [15:0]   linger;
  bit [15:0]   mask;
  result_t     awaited_results[$];
  int          errors;

  function new();
    foreach (room_valid[i]) room_valid[i] = 1'b0;
    next_room_id = 32'd1;
    cap          = SEAT_CAPACITY_RST;
    limit        = TYPE_LIMIT_RST;
    linger       = LINGER_TICKS_RST;
    mask         = KNOWN_MASK_RST;
    errors       = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SEAT_CAPACITY: cap = data[7:0];
      CFG_TYPE_LIMIT:    limit = data[4:0];
      CFG_LINGER_TICKS:  linger = data;
      CFG_KNOWN_MASK:    mask = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  // A random open room, for requests that should hit the table.
  function bit pick_room(output logic [31:0] id, output logic [3:0] kind);
    int open_idx[$];
    int pick;
    foreach (room_valid[i]) if (room_valid[i]) open_idx.insert(open_idx.size(), i);
    id   = '0;
    kind = '0;
    if (open_idx.size() == 0) return 1'b0;
    pick = open_idx[$urandom_range(0, open_idx.size() - 1)];
    id   = room_id[pick];
    kind = room_kind[pick];
    return 1'b1;
  endfunction

  // Mostly a joinable type, now and then any type at all.
  function logic [3:0] pick_type(int known_pct);
    logic [3:0] t;
    t = 4'($urandom_range(0, 15));
    if (mask != 16'd0 && $urandom_range(0, 99) < known_pct) begin
      while (!mask[t]) t = 4'($urandom_range(0, 15));
    end
    return t;
  endfunction

  function void note_request(item_t req);
    result_t   r;
    bit [7:0]  cap_e;
    bit [15:0] linger_e;
    bit        done;
    int        best;
    int        free_slot;
    int        kind_count;
    int        freed;
    int        rooms;
    int        seats;
    r        = '0;
    cap_e    = (cap == 8'd0) ? 8'd1 : cap;
    linger_e = (linger == 16'd0) ? 16'd1 : linger;
    case (req.mode)
      MODE_JOIN: begin
        if (!mask[req.room_type]) begin
          r.status = ST_UNKNOWN;
        end else begin
          done = 1'b0;
          // The preferred room wins only on an exact id and type match with
          // a seat to spare; the lowest slot is taken first.
          if (req.preferred_room != 32'd0) begin
            foreach (room_valid[i]) begin
              if (!done && room_valid[i] && room_id[i] == req.preferred_room &&
                  room_kind[i] == req.room_type && room_seats[i] < cap_e) begin
                room_seats[i]++;
                r.status       = ST_JOINED_PREF;
                r.granted_room = room_id[i];
                r.seats_taken  = room_seats[i];
                done           = 1'b1;
              end
            end
          end
          if (!done) begin
            best       = -1;
            free_slot  = -1;
            kind_count = 0;
            foreach (room_valid[i]) begin
              if (!room_valid[i]) begin
                if (free_slot < 0) free_slot = i;
              end else if (room_kind[i] == req.room_type) begin
                kind_count++;
                if (room_seats[i] < cap_e && (best < 0 || room_id[i] < room_id[best]))
                  best = i;
              end
            end
            if (best >= 0) begin
              room_seats[best]++;
              r.status       = ST_JOINED;
              r.granted_room = room_id[best];
              r.seats_taken  = room_seats[best];
            end else if (limit != 5'd0 && kind_count >= limit) begin
              r.status = ST_TYPE_LIMIT;
            end else if (free_slot < 0) begin
              r.status = ST_TABLE_FULL;
            end else begin
              room_valid[free_slot] = 1'b1;
              room_id[free_slot]    = next_room_id;
              room_kind[free_slot]  = req.room_type;
              room_seats[free_slot] = 8'd1;
              room_idle[free_slot]  = 16'd0;
              r.status              = ST_CREATED;
              r.granted_room        = next_room_id;
              r.seats_taken         = 8'd1;
              next_room_id++;
              if (next_room_id == 32'd0) next_room_id = 32'd1;
            end
          end
        end
      end
      MODE_LEAVE: begin
        done     = 1'b0;
        r.status = ST_LEAVE_MISS;
        if (req.leaving_room != 32'd0) begin
          foreach (room_valid[i]) begin
            if (!done && room_valid[i] && room_id[i] == req.leaving_room) begin
              if (room_seats[i] > 8'd0) room_seats[i]--;
              if (room_seats[i] == 8'd0) room_idle[i] = 16'd0;
              r.status       = ST_LEFT;
              r.granted_room = req.leaving_room;
              r.seats_taken  = room_seats[i];
              done           = 1'b1;
            end
          end
        end
      end
      MODE_TICK: begin
        foreach (room_valid[i])
          if (room_valid[i] && room_seats[i] == 8'd0 && room_idle[i] != 16'hFFFF)
            room_idle[i]++;
        r.status = ST_TICKED;
      end
      default: begin
        freed = 0;
        foreach (room_valid[i]) begin
          if (room_valid[i] && room_seats[i] == 8'd0 && room_idle[i] >= linger_e) begin
            room_valid[i] = 1'b0;
            freed++;
          end
        end
        r.status      = ST_REAPED;
        r.rooms_freed = freed[4:0];
      end
    endcase
    rooms = 0;
    seats = 0;
    foreach (room_valid[i]) begin
      if (room_valid[i]) begin
        rooms++;
        seats += room_seats[i];
      end
    end
    r.open_rooms  = rooms[4:0];
    r.total_seats = seats[11:0];
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: result word with status %0h arrived with nothing expected",
               $time, got.status);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("granted_room", want.granted_room, got.granted_room);
    compare_field("seats_taken", 32'(want.seats_taken), 32'(got.seats_taken));
    compare_field("rooms_freed", 32'(want.rooms_freed), 32'(got.rooms_freed));
    compare_field("open_rooms", 32'(want.open_rooms), 32'(got.open_rooms));
    compare_field("total_seats", 32'(want.total_seats), 32'(got.total_seats));
  endfunction
endclass

module testbench;

  // A register index that maps to no setting; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 8'd4;
  // The run limit leaves room for the worst gaps and stalls many times over.
  localparam int RUN_CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  bit   sender_calm = 1'b0;
  bit   receiver_calm = 1'b0;

  rsa_in_if  in_ch();
  rsa_out_if out_ch();
  rsa_cfg_if cfg_ch();

  seat_ledger ledger = new();

  room_seat_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Send one request word. The gap before it is drawn per word; now and then
  // the sender switches into a calm stretch without gaps. Valid stays high
  // after the handshake so that a following word with no gap goes straight
  // out; whoever pauses afterwards lowers it.
  task automatic request(mode_t m, logic [3:0] t, logic [31:0] p, logic [31:0] l);
    item_t req;
    int    gap;
    req.mode           = m;
    req.room_type      = t;
    req.preferred_room = p;
    req.leaving_room   = l;
    if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.mode           <= req.mode;
    in_ch.room_type      <= req.room_type;
    in_ch.preferred_room <= req.preferred_room;
    in_ch.leaving_room   <= req.leaving_room;
    in_ch.valid          <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.note_request(req);
  endtask

  // Hold the sender until every owed result word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four settings back to back, optionally preceded by a write to
  // an unmapped index. Only called while the block is idle.
  task automatic write_settings(logic [15:0] cap_word, logic [15:0] limit_word,
                                logic [15:0] linger_word, logic [15:0] mask_word,
                                bit stray);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] data[5];
    int                    first;
    idx[0]  = CFG_IDX_UNMAPPED;  data[0] = 16'hFFFF;
    idx[1]  = CFG_SEAT_CAPACITY; data[1] = cap_word;
    idx[2]  = CFG_TYPE_LIMIT;    data[2] = limit_word;
    idx[3]  = CFG_LINGER_TICKS;  data[3] = linger_word;
    idx[4]  = CFG_KNOWN_MASK;    data[4] = mask_word;
    first   = stray ? 0 : 1;
    for (int k = first; k < 5; k++) begin
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= data[k];
      cfg_ch.valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      ledger.write_reg(idx[k], data[k]);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random phase. Half of the joins and most leaves name rooms that are open,
  // so that preferred joins, full rooms and empty rooms come up often; the rest
  // of the words carry random ids and types. At word pause_at the sender waits
  // for the block to drain completely.
  task automatic random_phase(int n, int join_pct, int leave_pct, int tick_pct,
                              int known_pct, int pause_at);
    mode_t       m;
    logic [3:0]  t;
    logic [3:0]  kind;
    logic [31:0] p;
    logic [31:0] l;
    logic [31:0] id;
    int          roll;
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < join_pct) m = MODE_JOIN;
      else if (roll < join_pct + leave_pct) m = MODE_LEAVE;
      else if (roll < join_pct + leave_pct + tick_pct) m = MODE_TICK;
      else m = MODE_REAP;
      t    = ledger.pick_type(known_pct);
      p    = $urandom();
      l    = $urandom();
      roll = $urandom_range(0, 9);
      if (m == MODE_JOIN) begin
        if (roll < 5 && ledger.pick_room(id, kind)) begin
          p = id;
          if ($urandom_range(0, 9) < 7) t = kind;
        end else if (roll < 7) begin
          p = 32'd0;
        end
      end else if (m == MODE_LEAVE) begin
        if (roll < 8 && ledger.pick_room(id, kind)) l = id;
        else if (roll == 8) l = 32'd0;
      end
      request(m, t, p, l);
    end
  endtask

  // Result side: stall a drawn number of cycles before each word, then take
  // it and hand it to the ledger. Ready is only lowered when a stall is
  // actually drawn, so it never gets two updates in one step.
  initial begin
    result_t got;
    int      stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_calm = !receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      got.status       = status_t'(out_ch.status);
      got.granted_room = out_ch.granted_room;
      got.seats_taken  = out_ch.seats_taken;
      got.rooms_freed  = out_ch.rooms_freed;
      got.open_rooms   = out_ch.open_rooms;
      got.total_seats  = out_ch.total_seats;
      ledger.check_result(got);
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_JOIN;
    in_ch.room_type      = '0;
    in_ch.preferred_room = '0;
    in_ch.leaving_room   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: no type is known, so the join is refused. Leaves of
    // id zero and of an absent id miss; tick and reap on an empty table.
    request(MODE_JOIN, 4'd0, 32'd0, 32'hFFFF_FFFF);
    request(MODE_LEAVE, 4'd15, 32'hFFFF_FFFF, 32'd0);
    request(MODE_LEAVE, 4'd0, 32'd0, 32'hFFFF_FFFF);
    request(MODE_TICK, 4'd0, 32'd0, 32'd0);
    request(MODE_REAP, 4'd0, 32'd0, 32'd0);
    wait_drained();

    // Zero capacity acts as one seat, zero linger as one tick; one room per
    // type; only types 0 and 15 are known.
    write_settings(16'd0, 16'd1, 16'd0, 16'h8001, 1'b1);
    request(MODE_JOIN, 4'd0, 32'd0, 32'd0);                  // opens room 1
    request(MODE_JOIN, 4'd0, 32'hFFFF_FFFF, 32'd0);          // per-type limit
    request(MODE_JOIN, 4'd15, 32'd1, 32'd0);                 // preferred of other type
    request(MODE_JOIN, 4'd7, 32'd0, 32'd0);                  // type not known
    request(MODE_LEAVE, 4'd0, 32'd0, 32'd1);                 // room 1 goes empty
    request(MODE_LEAVE, 4'd0, 32'd0, 32'd1);                 // leave of an empty room
    request(MODE_TICK, 4'd0, 32'd0, 32'd0);
    request(MODE_REAP, 4'd0, 32'd0, 32'd0);                  // frees room 1
    request(MODE_LEAVE, 4'd0, 32'd0, 32'd1);                 // room 1 is gone
    wait_drained();

    // Widest settings: preferred and lowest-id joins into the same room.
    write_settings(16'd255, 16'd16, 16'hFFFF, 16'hFFFF, 1'b0);
    request(MODE_JOIN, 4'd15, 32'd2, 32'd0);
    request(MODE_JOIN, 4'd3, 32'd0, 32'd0);
    request(MODE_JOIN, 4'd3, 32'd0, 32'd0);
    request(MODE_JOIN, 4'd3, 32'd3, 32'd0);
    request(MODE_LEAVE, 4'd0, 32'd0, 32'd3);
    request(MODE_TICK, 4'd0, 32'd0, 32'd0);
    request(MODE_REAP, 4'd0, 32'd0, 32'd0);
    wait_drained();

    // Single-seat rooms, no type limit: the table fills up quickly.
    write_settings(16'd1, 16'd0, 16'd1, 16'hFFFF, 1'b0);
    random_phase(180, 60, 20, 10, 80, -1);
    wait_drained();

    // Tight per-type limit with half of the types unknown.
    write_settings(16'd3, 16'd2, 16'd2, 16'h0F0F, 1'b0);
    random_phase(180, 50, 25, 15, 80, -1);
    wait_drained();

    // One known type and full capacity: a room climbs to its last seat.
    // A third of the way through, the sender waits for the block to drain.
    write_settings(16'd255, 16'd16, 16'hFFFF, 16'h0001, 1'b0);
    random_phase(360, 90, 3, 4, 95, 120);
    wait_drained();

    // Upper data bits set: capacity reads as zero, the limit as 31.
    write_settings(16'hFF00, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    random_phase(150, 45, 25, 15, 80, -1);
    wait_drained();

    // Middle values with a random type mask.
    write_settings(16'd5, 16'd4, 16'd3, 16'($urandom_range(1, 65535)), 1'b0);
    random_phase(180, 45, 30, 15, 80, -1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rsa_pkg.sv
design/rsa_in_if.sv
design/rsa_out_if.sv
design/rsa_cfg_if.sv
design/rsa_ram.sv
design/rsa_cfg_regs.sv
design/rsa_scan.sv
design/room_seat_allocator.sv
test/testbench.sv
